// ===== hdl/ecu_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler angle to rotation
// matrix block. No dependencies.
`timescale 1ns / 1ps
package ecu_pkg;

  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;
  localparam int ANG_W         = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int STEP_W        = 5;
  localparam int DW            = 32;
  localparam int SUM_W         = DW + 1;
  localparam int OUT_SH        = 30 - OUT_FRAC_BITS;
  localparam int RED_W         = 18;

  localparam logic [RED_W-1:0] FULL_TURN    = RED_W'(23040);
  localparam logic [RED_W-1:0] QUARTER_TURN = RED_W'(5760);
  localparam logic signed [DW-1:0] CORDIC_K = 32'sd652032874;
  localparam logic signed [63:0] MUL_RND    = 64'sd536870912;
  localparam logic signed [SUM_W-1:0] OUT_RND =
    (OUT_SH > 0) ? SUM_W'(64'sd1 <<< ((OUT_SH > 0) ? OUT_SH - 1 : 0)) : '0;
  localparam logic signed [SUM_W-1:0] OUT_LIM = SUM_W'(64'sd1 <<< OUT_FRAC_BITS);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic [1:0]           q;
  } ecu_cordic_t;

  typedef struct packed {
    logic signed [DW-1:0] sn;
    logic signed [DW-1:0] cs;
  } ecu_sc_t;

  function automatic logic signed [DW-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic signed [DW-1:0] v;
    case (i)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      5'd20: v = 32'sd229;
      5'd21: v = 32'sd115;
      5'd22: v = 32'sd57;
      5'd23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic ecu_sc_t quad_map(input ecu_cordic_t c);
    ecu_sc_t r;
    case (c.q)
      QUAD_0: begin r.sn = c.y;  r.cs = c.x;  end
      QUAD_1: begin r.sn = c.x;  r.cs = -c.y; end
      QUAD_2: begin r.sn = -c.y; r.cs = -c.x; end
      default: begin r.sn = -c.x; r.cs = c.y; end
    endcase
    return r;
  endfunction

  function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + MUL_RND;
    return p[61:30];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + OUT_RND) >>> OUT_SH;
    if (t > OUT_LIM) t = OUT_LIM;
    if (t < -OUT_LIM) t = -OUT_LIM;
    return t[OUT_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [DW-1:0] a);
    return {a[DW-1], a};
  endfunction

endpackage

// ===== hdl/euler_ypr_to_rotation_matrix.sv =====
// Top level: Z-Y-X Euler angles to rotation matrix, three CORDIC cell chains and
// a two-stage product pipeline. Depends on ecu_pkg, ecu_angle_reduce, ecu_cordic_cell.
//
// Usage: drive in_yaw_angle, in_pitch_angle and in_roll_angle (signed, 1/64 degree)
// and pulse start. busy is always low, so a transaction is taken on every cycle
// in which start is high. Each transaction yields one result, after the pipeline
// below: out_valid is high for exactly one cycle with the nine
// matrix entries (signed Q2.16) and out_angle_error on the result ports. One
// result per cycle is sustained; the pipeline holds one register of angle
// reduction loaded at the accepting edge, one for each of the 24 CORDIC cells,
// one of quadrant correction, two multiply registers and the output register.
// The receiver cannot stall, so results are simply
// presented in order. Reset clears the valid pipeline; data registers are not
// reset. The block holds no state between transactions.
`timescale 1ns / 1ps
module euler_ypr_to_rotation_matrix import ecu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ANG_W-1:0] in_yaw_angle,
  input  logic signed [ANG_W-1:0] in_pitch_angle,
  input  logic signed [ANG_W-1:0] in_roll_angle,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_r00,
  output logic signed [OUT_W-1:0] out_r01,
  output logic signed [OUT_W-1:0] out_r02,
  output logic signed [OUT_W-1:0] out_r10,
  output logic signed [OUT_W-1:0] out_r11,
  output logic signed [OUT_W-1:0] out_r12,
  output logic signed [OUT_W-1:0] out_r20,
  output logic signed [OUT_W-1:0] out_r21,
  output logic signed [OUT_W-1:0] out_r22,
  output logic                    out_angle_error
);

  localparam int PIPE = CORDIC_STEPS + 4;

  ecu_cordic_t ch_a [0:CORDIC_STEPS];
  ecu_cordic_t ch_b [0:CORDIC_STEPS];
  ecu_cordic_t ch_g [0:CORDIC_STEPS];

  logic [PIPE-1:0] vld_r;
  logic [PIPE-1:0] err_r;
  logic            err_nxt;

  ecu_sc_t sca_r, scb_r, scg_r;
  logic signed [DW-1:0] casb_r, sasb_r, cacb_r, sacb_r, sacg_r, sasg_r;
  logic signed [DW-1:0] cacg_r, casg_r, cbsg_r, cbcg_r, sb_r;
  logic signed [DW-1:0] sg_d_r, cg_d_r;
  logic signed [DW-1:0] p01_r, p02_r, p11_r, p12_r;
  logic signed [DW-1:0] sacg2_r, sasg2_r, cacg2_r, casg2_r;
  logic signed [DW-1:0] cacb2_r, sacb2_r, cbsg2_r, cbcg2_r, sb2_r;

  assign busy = 1'b0;

  always_comb begin
    err_nxt = (in_yaw_angle < -16'sd23040) || (in_yaw_angle > 16'sd23040) ||
              (in_pitch_angle < -16'sd23040) || (in_pitch_angle > 16'sd23040) ||
              (in_roll_angle < -16'sd23040) || (in_roll_angle > 16'sd23040);
  end

  ecu_angle_reduce u_red_a (.clk(clk), .ang(in_yaw_angle),   .d_out(ch_a[0]));
  ecu_angle_reduce u_red_b (.clk(clk), .ang(in_pitch_angle), .d_out(ch_b[0]));
  ecu_angle_reduce u_red_g (.clk(clk), .ang(in_roll_angle),  .d_out(ch_g[0]));

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ecu_cordic_cell u_cell_a (.clk(clk), .step(STEP_W'(i)), .d_in(ch_a[i]),
                              .d_out(ch_a[i+1]));
    ecu_cordic_cell u_cell_b (.clk(clk), .step(STEP_W'(i)), .d_in(ch_b[i]),
                              .d_out(ch_b[i+1]));
    ecu_cordic_cell u_cell_g (.clk(clk), .step(STEP_W'(i)), .d_in(ch_g[i]),
                              .d_out(ch_g[i+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[PIPE-2:0], start & ~busy};
      out_valid <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    err_r <= {err_r[PIPE-2:0], err_nxt};

    sca_r <= quad_map(ch_a[CORDIC_STEPS]);
    scb_r <= quad_map(ch_b[CORDIC_STEPS]);
    scg_r <= quad_map(ch_g[CORDIC_STEPS]);

    casb_r <= qmul(sca_r.cs, scb_r.sn);
    sasb_r <= qmul(sca_r.sn, scb_r.sn);
    cacb_r <= qmul(sca_r.cs, scb_r.cs);
    sacb_r <= qmul(sca_r.sn, scb_r.cs);
    sacg_r <= qmul(sca_r.sn, scg_r.cs);
    sasg_r <= qmul(sca_r.sn, scg_r.sn);
    cacg_r <= qmul(sca_r.cs, scg_r.cs);
    casg_r <= qmul(sca_r.cs, scg_r.sn);
    cbsg_r <= qmul(scb_r.cs, scg_r.sn);
    cbcg_r <= qmul(scb_r.cs, scg_r.cs);
    sb_r   <= scb_r.sn;
    sg_d_r <= scg_r.sn;
    cg_d_r <= scg_r.cs;

    p01_r   <= qmul(casb_r, sg_d_r);
    p02_r   <= qmul(casb_r, cg_d_r);
    p11_r   <= qmul(sasb_r, sg_d_r);
    p12_r   <= qmul(sasb_r, cg_d_r);
    sacg2_r <= sacg_r;
    sasg2_r <= sasg_r;
    cacg2_r <= cacg_r;
    casg2_r <= casg_r;
    cacb2_r <= cacb_r;
    sacb2_r <= sacb_r;
    cbsg2_r <= cbsg_r;
    cbcg2_r <= cbcg_r;
    sb2_r   <= sb_r;

    out_r00 <= to_out(sx(cacb2_r));
    out_r01 <= to_out(sx(p01_r) - sx(sacg2_r));
    out_r02 <= to_out(sx(p02_r) + sx(sasg2_r));
    out_r10 <= to_out(sx(sacb2_r));
    out_r11 <= to_out(sx(p11_r) + sx(cacg2_r));
    out_r12 <= to_out(sx(p12_r) - sx(casg2_r));
    out_r20 <= to_out(-sx(sb2_r));
    out_r21 <= to_out(sx(cbsg2_r));
    out_r22 <= to_out(sx(cbcg2_r));
    out_angle_error <= err_r[PIPE-1];
  end

endmodule

// ===== hdl/ecu_angle_reduce.sv =====
// Registered reduction of one angle to quadrant and in-quadrant CORDIC start vector.
// Depends on ecu_pkg.
`timescale 1ns / 1ps
module ecu_angle_reduce import ecu_pkg::*; (
  input  logic                    clk,
  input  logic signed [ANG_W-1:0] ang,
  output ecu_cordic_t             d_out
);

  logic [RED_W-1:0] s;
  logic [RED_W-1:0] r;
  logic [RED_W-1:0] rem;
  logic [1:0]       q;
  ecu_cordic_t      d_nxt;
  ecu_cordic_t      d_r;

  always_comb begin
    s = RED_W'($signed({{(RED_W-ANG_W){ang[ANG_W-1]}}, ang}) + $signed(RED_W'(46080)));
    if (s >= RED_W'(3 * 23040)) r = s - RED_W'(3 * 23040);
    else if (s >= RED_W'(2 * 23040)) r = s - RED_W'(2 * 23040);
    else if (s >= FULL_TURN) r = s - FULL_TURN;
    else r = s;
    if (r >= RED_W'(3 * 5760)) begin
      q = QUAD_3; rem = r - RED_W'(3 * 5760);
    end else if (r >= RED_W'(2 * 5760)) begin
      q = QUAD_2; rem = r - RED_W'(2 * 5760);
    end else if (r >= QUARTER_TURN) begin
      q = QUAD_1; rem = r - QUARTER_TURN;
    end else begin
      q = QUAD_0; rem = r;
    end
    d_nxt.x = CORDIC_K;
    d_nxt.y = '0;
    d_nxt.z = $signed({1'b0, rem[12:0], 16'd0} & {DW{1'b1}});
    d_nxt.q = q;
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== hdl/ecu_cordic_cell.sv =====
// One rotation-mode CORDIC cell of the chain: one micro-rotation per cycle.
// Depends on ecu_pkg.
`timescale 1ns / 1ps
module ecu_cordic_cell import ecu_pkg::*; (
  input  logic              clk,
  input  logic [STEP_W-1:0] step,
  input  ecu_cordic_t       d_in,
  output ecu_cordic_t       d_out
);

  logic signed [DW-1:0] x;
  logic signed [DW-1:0] y;
  logic signed [DW-1:0] z;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  ecu_cordic_t          d_nxt;
  ecu_cordic_t          d_r;

  always_comb begin
    x  = d_in.x;
    y  = d_in.y;
    z  = d_in.z;
    xs = x >>> step;
    ys = y >>> step;
    d_nxt.q = d_in.q;
    if (!z[DW-1]) begin
      d_nxt.x = x - ys;
      d_nxt.y = y + xs;
      d_nxt.z = z - atan_val(step);
    end else begin
      d_nxt.x = x + ys;
      d_nxt.y = y - xs;
      d_nxt.z = z + atan_val(step);
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for euler_ypr_to_rotation_matrix: drives angle triples
// (with random gaps in part of the run) and checks each matrix result against a
// built-in predictor. Depends on ecu_pkg and the RTL of the block.
`timescale 1ns / 1ps

class matrix_scoreboard;
  logic [9*18:0] pending[$];
  int errors;
  int shown;

  function automatic longint qm(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic void sin_cos(longint ang, output longint sn, output longint cs);
    longint atan_steps[24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
      7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    longint r, z, x, y, nx;
    int q;
    r = (ang + 46080) % 23040;
    q = int'(r / 5760);
    z = (r % 5760) * 65536;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_steps[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_steps[i];
      end
      x = nx;
    end
    case (q)
      0: begin sn = y; cs = x; end
      1: begin sn = x; cs = -y; end
      2: begin sn = -y; cs = -x; end
      default: begin sn = -x; cs = y; end
    endcase
  endfunction

  function automatic logic [17:0] round_out(longint v);
    v = (v + 64'sd8192) >>> 14;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v[17:0];
  endfunction

  function void note_angles(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] g);
    longint sa, ca, sb, cb, sg, cg, casb, sasb;
    logic [9*18:0] e;
    sin_cos(a, sa, ca);
    sin_cos(b, sb, cb);
    sin_cos(g, sg, cg);
    casb = qm(ca, sb);
    sasb = qm(sa, sb);
    e[0] = (a < -23040 || a > 23040 || b < -23040 || b > 23040 ||
            g < -23040 || g > 23040);
    e[18*0+1 +: 18] = round_out(qm(ca, cb));
    e[18*1+1 +: 18] = round_out(qm(casb, sg) - qm(sa, cg));
    e[18*2+1 +: 18] = round_out(qm(casb, cg) + qm(sa, sg));
    e[18*3+1 +: 18] = round_out(qm(sa, cb));
    e[18*4+1 +: 18] = round_out(qm(sasb, sg) + qm(ca, cg));
    e[18*5+1 +: 18] = round_out(qm(sasb, cg) - qm(ca, sg));
    e[18*6+1 +: 18] = round_out(-sb);
    e[18*7+1 +: 18] = round_out(qm(cb, sg));
    e[18*8+1 +: 18] = round_out(qm(cb, cg));
    pending = {pending, e};
  endfunction

  function void check_matrix(logic [9*18:0] got);
    logic [9*18:0] e;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("Unexpected result transaction: %h", got);
      end
      return;
    end
    e = pending.pop_front();
    for (int f = 0; f < 10; f++) begin
      logic [17:0] ev, gv;
      ev = (f == 9) ? 18'(e[0]) : e[18*f+1 +: 18];
      gv = (f == 9) ? 18'(got[0]) : got[18*f+1 +: 18];
      if (ev !== gv) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("Mismatch field %0d: expected %h, actual %h", f, ev, gv);
        end
      end
    end
  endfunction
endclass

module testbench;
  import ecu_pkg::*;

  logic clk, rst_n, start, busy, out_valid, out_angle_error;
  logic signed [ANG_W-1:0] in_yaw_angle, in_pitch_angle, in_roll_angle;
  logic signed [OUT_W-1:0] out_r00, out_r01, out_r02, out_r10, out_r11, out_r12;
  logic signed [OUT_W-1:0] out_r20, out_r21, out_r22;
  matrix_scoreboard sb;

  euler_ypr_to_rotation_matrix dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_matrix({out_r22, out_r21, out_r20, out_r12, out_r11, out_r10,
                       out_r02, out_r01, out_r00, out_angle_error});
    if (rst_n && start && !busy)
      sb.note_angles(in_yaw_angle, in_pitch_angle, in_roll_angle);
  end

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 16)) * 1440 - 11520);
      2: return 16'($urandom_range(0, 8) - 4 + 5760 * $urandom_range(0, 4));
      default: return 16'(int'($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  task automatic send_angles(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] g, bit gaps);
    int idle;
    idle = 0;
    if (gaps)
      idle = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
             $urandom_range(0, 2);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    start <= 1'b1;
    in_yaw_angle <= a;
    in_pitch_angle <= b;
    in_roll_angle <= g;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic signed [15:0] edges[10] = '{0, 5760, 11520, 17280, 23040, -23040,
                                      23041, -23041, 16'sh7fff, 16'sh8000};
    sb = new();
    rst_n = 0;
    start = 0;
    in_yaw_angle = 0;
    in_pitch_angle = 0;
    in_roll_angle = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (edges[i])
      send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10], 0);
    send_angles(5759, -1, 1, 0);
    send_angles(-5760, 11519, -17281, 0);
    for (int n = 0; n < 1900; n++)
      send_angles(pick_angle(), pick_angle(), pick_angle(), (n / 300) % 2 == 0);
    start <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
